FILE: hdl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the voxel ray traversal unit.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int CELL_W  = 16;
    localparam int DIST_W  = 32;
    localparam int LEN_W   = 23;
    localparam int ORG_W   = 32;
    localparam int DIR_W   = 16;
    localparam int QUO_W   = 31;
    localparam int FRAC_W  = 16;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 23'd327680;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    localparam logic [1:0] STATUS_QUERY = 2'd0;
    localparam logic [1:0] STATUS_HIT   = 2'd1;
    localparam logic [1:0] STATUS_MISS  = 2'd2;
    localparam logic [1:0] STATUS_NORAY = 2'd3;

    localparam logic [2:0] FACE_FRONT  = 3'd0;
    localparam logic [2:0] FACE_TOP    = 3'd1;
    localparam logic [2:0] FACE_RIGHT  = 3'd2;
    localparam logic [2:0] FACE_BOTTOM = 3'd3;
    localparam logic [2:0] FACE_LEFT   = 3'd4;
    localparam logic [2:0] FACE_BACK   = 3'd5;
    localparam logic [2:0] FACE_INSIDE = 3'd6;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic              busy;
        logic              step_neg;
        logic [CELL_W-1:0] pos;
        logic [DIST_W-1:0] side;
    } lane_t;

    typedef struct packed {
        logic       any_below;
        axis_t      axis;
        logic [2:0] face;
    } sel_t;

endpackage

FILE: hdl/vrt_if.sv
// ----------------------------------------------------------------------------
// vrt_if
// Channel interfaces: ray/answer input, result output, length register write.
// ----------------------------------------------------------------------------
interface vrt_ray_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               solid;

    modport source (output valid, kind, origin_x, origin_y, origin_z,
                    dir_x, dir_y, dir_z, solid, input ready);
    modport sink   (input valid, kind, origin_x, origin_y, origin_z,
                    dir_x, dir_y, dir_z, solid, output ready);
endinterface

interface vrt_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [15:0] voxel_x;
    logic signed [15:0] voxel_y;
    logic signed [15:0] voxel_z;
    logic [2:0]         face;

    modport source (output valid, status, voxel_x, voxel_y, voxel_z, face,
                    input ready);
    modport sink   (input valid, status, voxel_x, voxel_y, voxel_z, face,
                    output ready);
endinterface

interface vrt_cfg_if;
    logic        valid;
    logic        ready;
    logic [22:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/vrt_axis_lane.sv
// ----------------------------------------------------------------------------
// vrt_axis_lane
// One axis of the walk: reciprocal by restoring division, initial side
// distance by one multiply, then saturating steps of the side distance.
// ----------------------------------------------------------------------------
module vrt_axis_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         origin,
    input  logic [15:0]         dir,
    input  logic                step_en,
    output vrt_pkg::lane_t      lane
);
    import vrt_pkg::*;

    typedef enum logic [1:0] {
        L_IDLE,
        L_DIV,
        L_MUL
    } lane_state_t;

    localparam logic [4:0] DIV_TOP = 5'(QUO_W - 1);

    lane_state_t       state_reg, state_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [DIST_W-1:0] side_reg, side_next;
    logic [DIST_W-1:0] cross_reg, cross_next;
    logic              neg_reg, neg_next;
    logic [15:0]       mag_reg, mag_next;
    logic [16:0]       dist_reg, dist_next;
    logic [15:0]       rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [4:0]        cnt_reg, cnt_next;

    logic [15:0]       mag_raw;
    logic [15:0]       mag_in;
    logic [16:0]       dist_in;
    logic [16:0]       shifted;
    logic              ge;
    logic [47:0]       prod;
    logic [DIST_W:0]   sum;

    assign mag_raw = dir[15] ? (~dir + 16'd1) : dir;
    assign mag_in  = (mag_raw == 16'd0) ? 16'd1 : mag_raw;
    assign dist_in = dir[15] ? {1'b0, origin[FRAC_W-1:0]}
                             : (17'h10000 - {1'b0, origin[FRAC_W-1:0]});
    assign shifted = {rem_reg, (cnt_reg == DIV_TOP)};
    assign ge      = (shifted >= {1'b0, mag_reg});
    assign prod    = {31'd0, dist_reg} * {17'd0, quo_reg};
    assign sum     = {1'b0, side_reg} + {1'b0, cross_reg};

    always_comb
    begin
        state_next = state_reg;
        cell_next  = cell_reg;
        side_next  = side_reg;
        cross_next = cross_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        dist_next  = dist_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            state_next = L_DIV;
            cell_next  = origin[31:16];
            neg_next   = dir[15];
            mag_next   = mag_in;
            dist_next  = dist_in;
            rem_next   = 16'd0;
            quo_next   = '0;
            cnt_next   = DIV_TOP;
        end
        else
        begin
            case (state_reg)
                L_IDLE:
                begin
                    if (step_en)
                    begin
                        side_next = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
                        cell_next = neg_reg ? (cell_reg - 16'd1) : (cell_reg + 16'd1);
                    end
                end
                L_DIV:
                begin
                    rem_next = ge ? 16'(shifted - {1'b0, mag_reg}) : shifted[15:0];
                    quo_next = {quo_reg[QUO_W-2:0], ge};
                    cnt_next = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_next = L_MUL;
                end
                L_MUL:
                begin
                    cross_next = {1'b0, quo_reg};
                    side_next  = prod[47:16];
                    state_next = L_IDLE;
                end
                default:
                begin
                    state_next = L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cell_reg  <= '0;
            side_reg  <= '0;
            cross_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cell_reg  <= cell_next;
            side_reg  <= side_next;
            cross_reg <= cross_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        dist_reg <= dist_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
    end

    assign lane.busy     = (state_reg != L_IDLE);
    assign lane.step_neg = neg_reg;
    assign lane.pos      = cell_reg;
    assign lane.side     = side_reg;

endmodule

FILE: hdl/vrt_step_sel.sv
// ----------------------------------------------------------------------------
// vrt_step_sel
// Merge of the three lanes: length test, smallest side distance and the
// face that the chosen step enters through.
// ----------------------------------------------------------------------------
module vrt_step_sel (
    input  vrt_pkg::lane_t [2:0]  lanes,
    input  logic [22:0]           max_length,
    output vrt_pkg::sel_t         sel
);
    import vrt_pkg::*;

    logic [DIST_W-1:0] lim;
    logic [DIST_W-1:0] sx, sy, sz;

    assign lim = {{(DIST_W-LEN_W){1'b0}}, max_length};
    assign sx  = lanes[0].side;
    assign sy  = lanes[1].side;
    assign sz  = lanes[2].side;

    always_comb
    begin
        sel.any_below = (sx < lim) || (sy < lim) || (sz < lim);
        if ((sx < sy) && (sx < sz))
            sel.axis = AXIS_X;
        else if (sy < sz)
            sel.axis = AXIS_Y;
        else
            sel.axis = AXIS_Z;
        case (sel.axis)
            AXIS_X:  sel.face = lanes[0].step_neg ? FACE_RIGHT : FACE_LEFT;
            AXIS_Y:  sel.face = lanes[1].step_neg ? FACE_TOP : FACE_BOTTOM;
            AXIS_Z:  sel.face = lanes[2].step_neg ? FACE_FRONT : FACE_BACK;
            default: sel.face = FACE_FRONT;
        endcase
    end

endmodule

FILE: hdl/voxel_ray_traversal_unit.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_unit
// 3D DDA voxel ray walk in fixed point, one lane per axis.
// ----------------------------------------------------------------------------
// ray_in takes a word that either starts a ray (origin Q16.16, direction
// Q1.14) or answers whether the last queried voxel is solid. res_out gives
// one word per input word: query, hit, miss or no-ray. cfg writes the ray
// length limit (Q16.16) and is always ready.
// A start word runs a restoring division per axis (one quotient bit per
// cycle, all three lanes side by side) and one multiply, then the emit
// stage; the next word is taken only after the emit stage has written
// its result.
// An answer word goes through decide and emit stages; the next word is
// taken only after the emit stage has written its result.
// The result register decouples the sides: one more word is accepted and
// processed while a result waits; the block then holds in its emit stage
// until res_out.ready frees the register.
// Reset clears the walk state (no ray active, face inside) and sets the
// length limit to 5.0 voxels.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_unit (
    input  logic      clk,
    input  logic      rst_n,
    vrt_ray_if.sink   ray_in,
    vrt_res_if.source res_out,
    vrt_cfg_if.sink   cfg
);
    import vrt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_EXEC,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic              solid_reg, solid_next;
    logic              active_reg, active_next;
    logic [2:0]        face_reg, face_next;
    logic [1:0]        rstat_reg, rstat_next;
    logic [2:0]        rface_reg, rface_next;
    logic              rzero_reg, rzero_next;
    logic              ovalid_reg, ovalid_next;
    logic [1:0]        ostat_reg, ostat_next;
    logic [2:0]        oface_reg, oface_next;
    logic [CELL_W-1:0] ox_reg, ox_next;
    logic [CELL_W-1:0] oy_reg, oy_next;
    logic [CELL_W-1:0] oz_reg, oz_next;
    logic [LEN_W-1:0]  maxlen_reg;

    logic              in_acc;
    logic              slot_free;
    logic              lane_start;
    logic [2:0]        step_en;
    logic [2:0][31:0]  origin_arr;
    logic [2:0][15:0]  dir_arr;
    lane_t [2:0]       lanes;
    sel_t              sel;

    assign ray_in.ready = (state_reg == S_IDLE);
    assign in_acc       = ray_in.valid && ray_in.ready;
    assign slot_free    = !ovalid_reg || res_out.ready;
    assign lane_start   = in_acc && (ray_in.kind == KIND_START);
    assign cfg.ready    = 1'b1;

    assign origin_arr[0] = ray_in.origin_x;
    assign origin_arr[1] = ray_in.origin_y;
    assign origin_arr[2] = ray_in.origin_z;
    assign dir_arr[0]    = ray_in.dir_x;
    assign dir_arr[1]    = ray_in.dir_y;
    assign dir_arr[2]    = ray_in.dir_z;

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_lane
            vrt_axis_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .start   (lane_start),
                .origin  (origin_arr[gi]),
                .dir     (dir_arr[gi]),
                .step_en (step_en[gi]),
                .lane    (lanes[gi])
            );
        end
    endgenerate

    vrt_step_sel u_sel (
        .lanes      (lanes),
        .max_length (maxlen_reg),
        .sel        (sel)
    );

    always_comb
    begin
        state_next  = state_reg;
        solid_next  = solid_reg;
        active_next = active_reg;
        face_next   = face_reg;
        rstat_next  = rstat_reg;
        rface_next  = rface_reg;
        rzero_next  = rzero_reg;
        ovalid_next = ovalid_reg && !res_out.ready;
        ostat_next  = ostat_reg;
        oface_next  = oface_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oz_next     = oz_reg;
        step_en     = 3'b000;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    solid_next = ray_in.solid;
                    if (ray_in.kind == KIND_START)
                    begin
                        active_next = 1'b1;
                        face_next   = FACE_INSIDE;
                        state_next  = S_INIT;
                    end
                    else
                        state_next = S_EXEC;
                end
            end
            S_INIT:
            begin
                if (!lanes[0].busy && !lanes[1].busy && !lanes[2].busy)
                begin
                    rstat_next = STATUS_QUERY;
                    rface_next = FACE_INSIDE;
                    rzero_next = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_EXEC:
            begin
                rzero_next = 1'b0;
                if (!active_reg)
                begin
                    rstat_next = STATUS_NORAY;
                    rface_next = FACE_FRONT;
                    rzero_next = 1'b1;
                end
                else if (solid_reg)
                begin
                    rstat_next  = STATUS_HIT;
                    rface_next  = face_reg;
                    active_next = 1'b0;
                end
                else if (!sel.any_below)
                begin
                    rstat_next  = STATUS_MISS;
                    rface_next  = FACE_FRONT;
                    active_next = 1'b0;
                end
                else
                begin
                    rstat_next = STATUS_QUERY;
                    rface_next = sel.face;
                    face_next  = sel.face;
                    case (sel.axis)
                        AXIS_X:  step_en = 3'b001;
                        AXIS_Y:  step_en = 3'b010;
                        AXIS_Z:  step_en = 3'b100;
                        default: step_en = 3'b000;
                    endcase
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = rstat_reg;
                    oface_next  = rface_reg;
                    ox_next     = rzero_reg ? '0 : lanes[0].pos;
                    oy_next     = rzero_reg ? '0 : lanes[1].pos;
                    oz_next     = rzero_reg ? '0 : lanes[2].pos;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
            face_reg   <= FACE_INSIDE;
            ovalid_reg <= 1'b0;
            maxlen_reg <= MAX_LENGTH_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            face_reg   <= face_next;
            ovalid_reg <= ovalid_next;
            if (cfg.valid && cfg.ready)
                maxlen_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        solid_reg <= solid_next;
        rstat_reg <= rstat_next;
        rface_reg <= rface_next;
        rzero_reg <= rzero_next;
        ostat_reg <= ostat_next;
        oface_reg <= oface_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
    end

    assign res_out.valid   = ovalid_reg;
    assign res_out.status  = ostat_reg;
    assign res_out.face    = oface_reg;
    assign res_out.voxel_x = ox_reg;
    assign res_out.voxel_y = oy_reg;
    assign res_out.voxel_z = oz_reg;

endmodule
